// File: hw/rtl/tkc_pkg.sv
// Package for the timestamped key cache: register codes, fixed field widths,
// reset values and the sequencer state type.
// No dependencies.
package tkc_pkg;

	// Fixed widths of the register and result fields.
	localparam int CAP_W     = 7;
	localparam int REFRESH_W = 20;
	localparam int COUNT_W   = 7;
	localparam int APB_W     = 32;
	localparam int PADDR_W   = 3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_REFRESH  = 1'b1;

	localparam logic [CAP_W-1:0]     CAPACITY_RESET = 7'd64;
	localparam logic [REFRESH_W-1:0] REFRESH_RESET  = 20'd86400;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_LOOK   = 8'b0000_0010,
		ST_DECIDE = 8'b0000_0100,
		ST_EVCHK  = 8'b0000_1000,
		ST_EVSCAN = 8'b0001_0000,
		ST_EVPICK = 8'b0010_0000,
		ST_MOVE   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

endpackage

// File: hw/rtl/tkc_channels.sv
// Valid/ready channel interfaces of the timestamped key cache.
// Depends on tkc_pkg for the result count width.
interface tkc_in_if #(
	parameter int KEY_BITS  = 64,
	parameter int TIME_BITS = 40
);
	logic                 valid;
	logic                 ready;
	logic [KEY_BITS-1:0]  key;
	logic [TIME_BITS-1:0] now_seconds;

	modport source (output valid, key, now_seconds, input ready);
	modport sink   (input valid, key, now_seconds, output ready);
endinterface

interface tkc_out_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [tkc_pkg::COUNT_W-1:0] evicted_count;
	logic [tkc_pkg::COUNT_W-1:0] entry_count;

	modport source (output valid, accepted, evicted_count, entry_count, input ready);
	modport sink   (input valid, accepted, evicted_count, entry_count, output ready);
endinterface

// File: hw/rtl/timestamped_key_cache.sv
// Timestamped key cache: a table of keys with last-noted times, bounded by a
// capacity, evicting the oldest entries. Depends on tkc_pkg and tkc_channels.
//
//   channel  | dir | transaction
//   ---------+-----+-------------------------------------------------
//   item     | in  | key, now_seconds
//   result   | out | accepted, evicted_count, entry_count
//   APB      | in  | register writes and reads (capacity, refresh_seconds)
//
// Each transaction first scans the whole table memory for its key, then decides;
// an empty key skips the scan. Every eviction adds a check, another full scan for
// the oldest entry and a pick. The table memory has a single read port. Reset
// clears the valid bits and count at once; the table memory needs no clearing. A
// new item is taken while a result still waits; a result that is not taken holds
// the next one in its last state.
module timestamped_key_cache #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_BITS    = 64,
	parameter int TIME_BITS   = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tkc_in_if.sink                              item,
	tkc_out_if.source                           result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tkc_pkg::PADDR_W-1:0]         paddr,
	input  logic [tkc_pkg::APB_W-1:0]           pwdata,
	output logic [tkc_pkg::APB_W-1:0]           prdata,
	output logic                                pready
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 2);
	localparam int LW = (CW > tkc_pkg::COUNT_W) ? CW : tkc_pkg::COUNT_W;
	localparam int EW = KEY_BITS + TIME_BITS;
	localparam logic [AW:0] DEPTH_CNT = (AW+1)'(TABLE_DEPTH);
	localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

	tkc_pkg::state_t state_q;

	logic [EW-1:0] mem [TABLE_DEPTH];
	logic [EW-1:0] mem_rd_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          rd_vld_s1;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0]          total_q;
	logic [CW-1:0]          evicted_q;
	logic                   accepted_q;
	logic                   stage_vld_q;

	logic [tkc_pkg::CAP_W-1:0]     capacity_q;
	logic [tkc_pkg::REFRESH_W-1:0] refresh_q;

	logic [KEY_BITS-1:0]  key_q;
	logic [TIME_BITS-1:0] now_q;

	logic [AW:0]          scan_q;
	logic                 hit_q;
	logic [AW-1:0]        hit_idx_q;
	logic [TIME_BITS-1:0] hit_time_q;
	logic                 free_q;
	logic [AW-1:0]        free_idx_q;
	logic                 best_q;
	logic [AW-1:0]        best_idx_q;
	logic [EW-1:0]        best_ent_q;

	logic                        out_valid_q;
	logic                        res_accepted_q;
	logic [tkc_pkg::COUNT_W-1:0] res_evicted_q;
	logic [tkc_pkg::COUNT_W-1:0] res_count_q;

	logic                 issue;
	logic                 scan_end;
	logic [KEY_BITS-1:0]  rd_key;
	logic [TIME_BITS-1:0] rd_time;
	logic                 rd_entry_vld;
	logic [TIME_BITS:0]   age;
	logic                 refuse;
	logic [LW-1:0]        limit;
	logic [LW-1:0]        cap_l;
	logic [LW-1:0]        total_l;
	logic                 over_cap;
	logic                 staged_older;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic                 cfg_wr;
	logic                 result_free;

	assign issue    = (state_q == tkc_pkg::ST_LOOK || state_q == tkc_pkg::ST_EVSCAN) &&
	                  (scan_q != DEPTH_CNT);
	assign scan_end = (scan_q == DEPTH_CNT) && !rd_vld_s1;

	assign rd_key       = mem_rd_s1[EW-1:TIME_BITS];
	assign rd_time      = mem_rd_s1[TIME_BITS-1:0];
	assign rd_entry_vld = valid_q[rd_idx_s1];

	// Age is a signed difference; a time that runs backwards is refused.
	assign age    = {1'b0, now_q} - {1'b0, hit_time_q};
	assign refuse = $signed(age) <
	                $signed({{(TIME_BITS+1-tkc_pkg::REFRESH_W){1'b0}}, refresh_q});

	assign cap_l    = LW'(capacity_q);
	assign limit    = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
	assign total_l  = LW'(total_q);
	assign over_cap = total_l > limit;

	// Entries are ranked by time, then key. Keys are unique among valid entries,
	// so the order is strict.
	assign staged_older = stage_vld_q && (!best_q || ({now_q, key_q} < best_ent_q));

	assign wr_en   = (state_q == tkc_pkg::ST_DECIDE && !(hit_q && refuse) && (hit_q || free_q)) ||
	                 (state_q == tkc_pkg::ST_MOVE && stage_vld_q && free_q);
	assign wr_addr = (state_q == tkc_pkg::ST_DECIDE && hit_q) ? hit_idx_q : free_idx_q;

	assign cfg_wr      = psel && penable && pwrite;
	assign result_free = !out_valid_q || result.ready;

	assign item.ready           = (state_q == tkc_pkg::ST_IDLE);
	assign result.valid         = out_valid_q;
	assign result.accepted      = res_accepted_q;
	assign result.evicted_count = res_evicted_q;
	assign result.entry_count   = res_count_q;

	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			tkc_pkg::REG_CAPACITY: prdata = {{(tkc_pkg::APB_W-tkc_pkg::CAP_W){1'b0}}, capacity_q};
			tkc_pkg::REG_REFRESH:  prdata = {{(tkc_pkg::APB_W-tkc_pkg::REFRESH_W){1'b0}}, refresh_q};
			default:               prdata = '0;
		endcase
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {key_q, now_q};
		end
		mem_rd_s1 <= mem[scan_q[AW-1:0]];
		rd_idx_s1 <= scan_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tkc_pkg::ST_IDLE;
			capacity_q     <= tkc_pkg::CAPACITY_RESET;
			refresh_q      <= tkc_pkg::REFRESH_RESET;
			valid_q        <= '0;
			total_q        <= '0;
			evicted_q      <= '0;
			accepted_q     <= 1'b0;
			stage_vld_q    <= 1'b0;
			scan_q         <= '0;
			rd_vld_s1      <= 1'b0;
			hit_q          <= 1'b0;
			free_q         <= 1'b0;
			best_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			res_accepted_q <= 1'b0;
			res_evicted_q  <= '0;
			res_count_q    <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end

			if (cfg_wr) begin
				case (paddr[2])
					tkc_pkg::REG_CAPACITY: capacity_q <= pwdata[tkc_pkg::CAP_W-1:0];
					tkc_pkg::REG_REFRESH:  refresh_q  <= pwdata[tkc_pkg::REFRESH_W-1:0];
					default: ;
				endcase
			end

			// In the last state the result register is refilled instead.
			if (out_valid_q && result.ready && state_q != tkc_pkg::ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				tkc_pkg::ST_IDLE: begin
					if (item.valid) begin
						key_q      <= item.key;
						now_q      <= item.now_seconds;
						accepted_q <= 1'b0;
						evicted_q  <= '0;
						scan_q     <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						state_q    <= (item.key == '0) ? tkc_pkg::ST_DONE : tkc_pkg::ST_LOOK;
					end
				end
				tkc_pkg::ST_LOOK: begin
					if (rd_vld_s1) begin
						if (rd_entry_vld && rd_key == key_q && !hit_q) begin
							hit_q      <= 1'b1;
							hit_idx_q  <= rd_idx_s1;
							hit_time_q <= rd_time;
						end
						if (!rd_entry_vld && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
					end
					if (scan_end) begin
						state_q <= tkc_pkg::ST_DECIDE;
					end
				end
				tkc_pkg::ST_DECIDE: begin
					if (hit_q && refuse) begin
						state_q <= tkc_pkg::ST_DONE;
					end else begin
						accepted_q <= 1'b1;
						if (!hit_q) begin
							total_q <= total_q + 1'b1;
							if (free_q) begin
								valid_q[free_idx_q] <= 1'b1;
								free_q              <= 1'b0;
							end else begin
								stage_vld_q <= 1'b1;
							end
						end
						state_q <= tkc_pkg::ST_EVCHK;
					end
				end
				tkc_pkg::ST_EVCHK: begin
					if (over_cap) begin
						scan_q  <= '0;
						best_q  <= 1'b0;
						state_q <= tkc_pkg::ST_EVSCAN;
					end else begin
						state_q <= tkc_pkg::ST_MOVE;
					end
				end
				tkc_pkg::ST_EVSCAN: begin
					if (rd_vld_s1 && rd_entry_vld &&
					    (!best_q || ({rd_time, rd_key} < best_ent_q))) begin
						best_q     <= 1'b1;
						best_idx_q <= rd_idx_s1;
						best_ent_q <= {rd_time, rd_key};
					end
					if (scan_end) begin
						state_q <= tkc_pkg::ST_EVPICK;
					end
				end
				tkc_pkg::ST_EVPICK: begin
					if (staged_older) begin
						stage_vld_q <= 1'b0;
						total_q     <= total_q - 1'b1;
						evicted_q   <= evicted_q + 1'b1;
						state_q     <= tkc_pkg::ST_EVCHK;
					end else if (best_q) begin
						valid_q[best_idx_q] <= 1'b0;
						// The lowest freed slot takes a surviving staged key.
						if (!free_q || best_idx_q < free_idx_q) begin
							free_q     <= 1'b1;
							free_idx_q <= best_idx_q;
						end
						total_q   <= total_q - 1'b1;
						evicted_q <= evicted_q + 1'b1;
						state_q   <= tkc_pkg::ST_EVCHK;
					end else begin
						state_q <= tkc_pkg::ST_MOVE;
					end
				end
				tkc_pkg::ST_MOVE: begin
					if (stage_vld_q && free_q) begin
						valid_q[free_idx_q] <= 1'b1;
						stage_vld_q         <= 1'b0;
					end
					state_q <= tkc_pkg::ST_DONE;
				end
				tkc_pkg::ST_DONE: begin
					if (result_free) begin
						out_valid_q    <= 1'b1;
						res_accepted_q <= accepted_q;
						res_evicted_q  <= tkc_pkg::COUNT_W'(LW'(evicted_q));
						res_count_q    <= tkc_pkg::COUNT_W'(total_l);
						state_q        <= tkc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tkc_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
